### sv/ecf_pkg.sv
// ecf_pkg: types, sizes and microcode program of the euler circuit finder
// used by euler_circuit_finder_unit and ecf_checker; no dependencies
`default_nettype none

package ecf_pkg;

  // sizes
  localparam int unsigned MAX_VERTICES = 8;
  localparam int unsigned MAX_PATH     = 37;
  localparam int unsigned VTX_W        = 4;
  localparam int unsigned ROW_BITS_W   = 8;
  localparam int unsigned VIDX_W       = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned ADDR_W       = $clog2(MAX_PATH);
  localparam int unsigned PTR_W        = $clog2(MAX_PATH + 1);

  // request and result payloads
  typedef struct packed {
    logic                  command;
    logic [VTX_W-1:0]      row_index;
    logic [ROW_BITS_W-1:0] row_bits;
    logic [VTX_W-1:0]      start_vertex;
  } req_t;

  typedef struct packed {
    logic [VTX_W-1:0] vertex;
    logic             last;
  } rsp_t;

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_WALK = 1'b1;

  // datapath actions, one-hot
  typedef enum logic [7:0] {
    A_IDLE = 8'b0000_0001,
    A_FIND = 8'b0000_0010,
    A_PUSH = 8'b0000_0100,
    A_CLR  = 8'b0000_1000,
    A_POP  = 8'b0001_0000,
    A_LOAD = 8'b0010_0000,
    A_ERD  = 8'b0100_0000,
    A_EMIT = 8'b1000_0000
  } act_e;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOWALK,
    C_NOEDGE,
    C_EMPTY,
    C_MORE
  } cond_e;

  // program step addresses
  typedef logic [2:0] step_t;
  localparam step_t STEP_IDLE = 3'd0;
  localparam step_t STEP_FIND = 3'd1;
  localparam step_t STEP_PUSH = 3'd2;
  localparam step_t STEP_CLR  = 3'd3;
  localparam step_t STEP_POP  = 3'd4;
  localparam step_t STEP_LOAD = 3'd5;
  localparam step_t STEP_ERD  = 3'd6;
  localparam step_t STEP_EMIT = 3'd7;

  // control word: action, jump when cond holds, else go to seq
  typedef struct packed {
    act_e  act;
    cond_e cond;
    step_t jmp;
    step_t seq;
  } uword_t;

  // microcode rom
  function automatic uword_t ucode_rom(input step_t pc);
    uword_t w;
    case (pc)
      STEP_IDLE: w = '{act: A_IDLE, cond: C_NOWALK, jmp: STEP_IDLE, seq: STEP_FIND};
      STEP_FIND: w = '{act: A_FIND, cond: C_NOEDGE, jmp: STEP_POP,  seq: STEP_PUSH};
      STEP_PUSH: w = '{act: A_PUSH, cond: C_NEVER,  jmp: STEP_IDLE, seq: STEP_CLR};
      STEP_CLR:  w = '{act: A_CLR,  cond: C_ALWAYS, jmp: STEP_FIND, seq: STEP_FIND};
      STEP_POP:  w = '{act: A_POP,  cond: C_EMPTY,  jmp: STEP_ERD,  seq: STEP_LOAD};
      STEP_LOAD: w = '{act: A_LOAD, cond: C_ALWAYS, jmp: STEP_FIND, seq: STEP_FIND};
      STEP_ERD:  w = '{act: A_ERD,  cond: C_NEVER,  jmp: STEP_IDLE, seq: STEP_EMIT};
      STEP_EMIT: w = '{act: A_EMIT, cond: C_MORE,   jmp: STEP_ERD,  seq: STEP_IDLE};
      default:   w = '{act: A_IDLE, cond: C_NEVER,  jmp: STEP_IDLE, seq: STEP_IDLE};
    endcase
    return w;
  endfunction

  // 1-based vertex number to row index
  function automatic logic [VIDX_W-1:0] vtx_to_idx(input logic [VTX_W-1:0] v);
    logic [VTX_W-1:0] d;
    d = v - VTX_W'(1);
    return d[VIDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

### sv/euler_circuit_finder_unit.sv
// euler_circuit_finder_unit: microcoded hierholzer walk over an adjacency bit matrix
// depends on ecf_pkg
`default_nettype none

// A request with command load writes one adjacency row. A request with command
// walk and a start vertex in 1..vertex_count (at most MAX_VERTICES) runs the
// walk: busy_o stays high while a microcode sequencer steps the datapath. Each
// pushed edge takes the steps find, push and clear reverse edge, each pop a
// failed find, pop and reload of the top from the stack memory, the final pop
// skips the reload, and each emitted vertex takes a circuit memory read and an
// output; the next request is taken once the sequencer is back in idle.
// Results appear with result_valid_o for exactly one cycle each and cannot be
// stalled; the final one carries last. A walk request with a start out of
// range returns at once with no results. Edges are consumed, so rows must be
// reloaded before the next walk. The user must write vertex_count through
// cfg_we_i only while idle; the block itself does not enforce it.
module euler_circuit_finder_unit (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire [ecf_pkg::VTX_W-1:0] cfg_wdata_i,
  input  wire                 start_i,
  input  ecf_pkg::req_t       req_i,
  output logic                busy_o,
  output logic                result_valid_o,
  output ecf_pkg::rsp_t       rsp_o
);

  // sequencer and control state
  ecf_pkg::step_t              pc_q, pc_d;
  logic [ecf_pkg::VTX_W-1:0]   vcount_q;
  logic [ecf_pkg::PTR_W-1:0]   depth_q, depth_d;
  logic [ecf_pkg::PTR_W-1:0]   len_q, len_d;
  logic [ecf_pkg::ADDR_W-1:0]  emit_idx_q, emit_idx_d;

  // payload registers
  logic [ecf_pkg::VTX_W-1:0]   top_q, top_d;
  logic [ecf_pkg::VTX_W-1:0]   v_q, x_q;
  logic [ecf_pkg::VTX_W-1:0]   stk_rd_q, lst_rd_q;
  logic [ecf_pkg::MAX_VERTICES-1:0] adj_q [ecf_pkg::MAX_VERTICES];

  // memories
  logic [ecf_pkg::VTX_W-1:0]   stk_mem [ecf_pkg::MAX_PATH];
  logic [ecf_pkg::VTX_W-1:0]   lst_mem [ecf_pkg::MAX_PATH];

  ecf_pkg::uword_t             uw;
  logic                        accept, walk_ok, cond_hit;
  logic [ecf_pkg::VTX_W-1:0]   n_eff, x_find;
  logic [ecf_pkg::MAX_VERTICES-1:0] nmask, cand;
  logic                        found, room, list_room;
  logic [ecf_pkg::PTR_W:0]     used;

  // fetch the control word
  assign uw     = ecf_pkg::ucode_rom(pc_q);
  assign accept = start_i && !busy_o;

  // effective vertex count and neighbour mask
  always_comb begin
    n_eff = (vcount_q > ecf_pkg::VTX_W'(ecf_pkg::MAX_VERTICES)) ?
            ecf_pkg::VTX_W'(ecf_pkg::MAX_VERTICES) : vcount_q;
    for (int i = 0; i < ecf_pkg::MAX_VERTICES; i++) begin
      nmask[i] = ecf_pkg::VTX_W'(i) < n_eff;
    end
  end

  assign walk_ok = (req_i.start_vertex != '0) && (req_i.start_vertex <= n_eff);

  // lowest neighbour of the top vertex
  always_comb begin
    cand   = adj_q[ecf_pkg::vtx_to_idx(top_q)] & nmask;
    found  = 1'b0;
    x_find = '0;
    for (int i = ecf_pkg::MAX_VERTICES - 1; i >= 0; i--) begin
      if (cand[i]) begin
        found  = 1'b1;
        x_find = ecf_pkg::VTX_W'(i + 1);
      end
    end
  end

  // capacity of stack plus circuit list
  assign used      = {1'b0, depth_q} + {1'b0, len_q};
  assign room      = used < (ecf_pkg::PTR_W + 1)'(ecf_pkg::MAX_PATH);
  assign list_room = len_q < ecf_pkg::PTR_W'(ecf_pkg::MAX_PATH);

  // jump condition
  always_comb begin
    case (uw.cond)
      ecf_pkg::C_NEVER:  cond_hit = 1'b0;
      ecf_pkg::C_ALWAYS: cond_hit = 1'b1;
      ecf_pkg::C_NOWALK: cond_hit = !(accept && req_i.command == ecf_pkg::CMD_WALK && walk_ok);
      ecf_pkg::C_NOEDGE: cond_hit = !(found && room);
      ecf_pkg::C_EMPTY:  cond_hit = depth_q == ecf_pkg::PTR_W'(1);
      ecf_pkg::C_MORE:   cond_hit = emit_idx_q != '0;
      default:           cond_hit = 1'b0;
    endcase
    pc_d = cond_hit ? uw.jmp : uw.seq;
  end

  // control datapath next values
  always_comb begin
    depth_d    = depth_q;
    len_d      = len_q;
    emit_idx_d = emit_idx_q;
    top_d      = top_q;
    case (uw.act)
      ecf_pkg::A_IDLE: begin
        if (accept && req_i.command == ecf_pkg::CMD_WALK) begin
          depth_d = walk_ok ? ecf_pkg::PTR_W'(1) : '0;
          len_d   = '0;
          top_d   = req_i.start_vertex;
        end
      end
      ecf_pkg::A_PUSH: begin
        depth_d = depth_q + ecf_pkg::PTR_W'(1);
        top_d   = x_q;
      end
      ecf_pkg::A_POP: begin
        depth_d = depth_q - ecf_pkg::PTR_W'(1);
        if (list_room) begin
          len_d = len_q + ecf_pkg::PTR_W'(1);
        end
        emit_idx_d = ecf_pkg::ADDR_W'(len_d - ecf_pkg::PTR_W'(1));
      end
      ecf_pkg::A_LOAD: top_d = stk_rd_q;
      ecf_pkg::A_EMIT: begin
        if (emit_idx_q != '0) begin
          emit_idx_d = emit_idx_q - ecf_pkg::ADDR_W'(1);
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q       <= ecf_pkg::STEP_IDLE;
      vcount_q   <= ecf_pkg::VTX_W'(ecf_pkg::MAX_VERTICES);
      depth_q    <= '0;
      len_q      <= '0;
      emit_idx_q <= '0;
    end else begin
      pc_q       <= pc_d;
      depth_q    <= depth_d;
      len_q      <= len_d;
      emit_idx_q <= emit_idx_d;
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
      end
    end
  end

  // walk registers and adjacency rows
  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (uw.act == ecf_pkg::A_FIND) begin
      x_q <= x_find;
      v_q <= top_q;
    end
    if (uw.act == ecf_pkg::A_IDLE && accept && req_i.command == ecf_pkg::CMD_LOAD &&
        req_i.row_index != '0 &&
        req_i.row_index <= ecf_pkg::VTX_W'(ecf_pkg::MAX_VERTICES)) begin
      adj_q[ecf_pkg::vtx_to_idx(req_i.row_index)] <=
        req_i.row_bits[ecf_pkg::MAX_VERTICES-1:0];
    end else if (uw.act == ecf_pkg::A_PUSH) begin
      adj_q[ecf_pkg::vtx_to_idx(v_q)] <= adj_q[ecf_pkg::vtx_to_idx(v_q)] &
        ~(ecf_pkg::MAX_VERTICES'(1) << ecf_pkg::vtx_to_idx(x_q));
    end else if (uw.act == ecf_pkg::A_CLR) begin
      adj_q[ecf_pkg::vtx_to_idx(x_q)] <= adj_q[ecf_pkg::vtx_to_idx(x_q)] &
        ~(ecf_pkg::MAX_VERTICES'(1) << ecf_pkg::vtx_to_idx(v_q));
    end
  end

  // stack memory: entries below the top register
  always_ff @(posedge clk_i) begin
    if (uw.act == ecf_pkg::A_PUSH) begin
      stk_mem[ecf_pkg::ADDR_W'(depth_q - ecf_pkg::PTR_W'(1))] <= top_q;
    end
    if (uw.act == ecf_pkg::A_POP && depth_q > ecf_pkg::PTR_W'(1)) begin
      stk_rd_q <= stk_mem[ecf_pkg::ADDR_W'(depth_q - ecf_pkg::PTR_W'(2))];
    end
  end

  // circuit list memory
  always_ff @(posedge clk_i) begin
    if (uw.act == ecf_pkg::A_POP && list_room) begin
      lst_mem[ecf_pkg::ADDR_W'(len_q)] <= top_q;
    end
    if (uw.act == ecf_pkg::A_ERD) begin
      lst_rd_q <= lst_mem[emit_idx_q];
    end
  end

  // result ports
  assign busy_o         = pc_q != ecf_pkg::STEP_IDLE;
  assign result_valid_o = uw.act == ecf_pkg::A_EMIT;
  assign rsp_o.vertex   = lst_rd_q;
  assign rsp_o.last     = emit_idx_q == '0;

endmodule

`default_nettype wire

### sv/ecf_checker.sv
// ecf_checker: port-level assertions for euler_circuit_finder_unit, with its bind
// depends on ecf_pkg
`default_nettype none

module ecf_checker (
  input wire           clk_i,
  input wire           rst_ni,
  input wire           start_i,
  input ecf_pkg::req_t req_i,
  input wire           busy_o,
  input wire           result_valid_o,
  input ecf_pkg::rsp_t rsp_o
);

  // results only come out during a walk
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o) else $error("result outside a walk");

  // the final result ends the walk
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && rsp_o.last |=> !busy_o) else $error("busy after last result");

  // results are never back to back: a circuit memory read comes between them
  a_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !rsp_o.last |=> !result_valid_o && busy_o)
    else $error("results back to back or walk dropped");

  // a row load never starts a walk
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && req_i.command == ecf_pkg::CMD_LOAD |=> !busy_o)
    else $error("row load made the block busy");

  // a walk always ends with its last result
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> $past(result_valid_o && rsp_o.last))
    else $error("walk ended without a last result");

endmodule

bind euler_circuit_finder_unit ecf_checker u_ecf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .req_i          (req_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .rsp_o          (rsp_o)
);

`default_nettype wire
